// ===== src/sgu_pkg.sv =====
// Shared types and constants for the speaker gain / upsample / reference ring block.
package sgu_pkg;

   localparam int OP_W      = 2;
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 11;
   localparam int FRAC_W    = 10;
   localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

   localparam logic [OP_W-1:0] OP_PLAY   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_IGNORE = 2'd3;

   localparam logic KIND_SPEAKER = 1'b0;
   localparam logic KIND_REF     = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_RESET  = 11'd717;
   localparam logic [GAIN_W-1:0] GAIN_BYPASS = 11'd1023;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [OP_W-1:0]            op;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_end;
   } cmd_type;

endpackage

// ===== src/sgu_chan_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface sgu_req_if;
   logic                                valid;
   logic                                ready;
   logic [sgu_pkg::OP_W-1:0]            op;
   logic signed [sgu_pkg::SAMPLE_W-1:0] in_sample;
   logic                                frame_end;

   modport source (output valid, op, in_sample, frame_end, input ready);
   modport sink   (input valid, op, in_sample, frame_end, output ready);
endinterface

interface sgu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [sgu_pkg::SAMPLE_W-1:0] sample;
   logic                                last;
   logic                                packet_end;
   logic                                underflow;

   modport source (output valid, kind, sample, last, packet_end, underflow, input ready);
   modport sink   (input valid, kind, sample, last, packet_end, underflow, output ready);
endinterface

// ===== src/speaker_gain_upsample_ref_ring.sv =====
// Top level: speaker gain stage, zero-order-hold upsampler and reference ring.
// A play beat is scaled by the Q1.10 gain (1023 and up passes the sample
// through), pushed into a REF_DEPTH-entry reference ring that drops its oldest
// entry when full, and sent out UPSAMPLE times; a read beat pops one ring entry
// (or returns zero with underflow set when the ring is empty); a clear beat
// empties the ring; op 3 is discarded. Throughput is set by the back end,
// which drives one response beat per cycle unless the output stalls: a play
// takes UPSAMPLE beats, a read one beat and a clear none, and the next item
// may start as the last beat goes out, so plays stream with no bubbles. The
// front end registers the gain product and feeds a four-entry command queue,
// so requests keep flowing while the output is stalled until the queue fills.
// A request passes the front-end register, queue and back-end register before
// its first beat shows in the output register. The ring has no reset pass:
// it is usable from the first cycle after reset; gain writes are registered.
module speaker_gain_upsample_ref_ring #(
   parameter int REF_DEPTH = 16384,
   parameter int UPSAMPLE  = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [sgu_pkg::GAIN_W-1:0] csr_wr_data,
   sgu_req_if.sink                    req_bus,
   sgu_rsp_if.source                  rsp_bus
);

   logic             push_valid;
   sgu_pkg::cmd_type push_data;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;
   sgu_pkg::cmd_type q_head;

   sgu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .q_full      (q_full)
   );

   sgu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   sgu_back #(
      .REF_DEPTH (REF_DEPTH),
      .UPSAMPLE  (UPSAMPLE)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== src/sgu_front.sv =====
// Front end: gain register, request intake, gain multiply and command classification.
module sgu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sgu_pkg::GAIN_W-1:0]    csr_wr_data,
   sgu_req_if.sink                       req_bus,
   output logic                          push_valid,
   output sgu_pkg::cmd_type              push_data,
   input  logic                          q_full
);

   logic [sgu_pkg::GAIN_W-1:0]            gain_ff;
   logic                                  f_valid_ff, f_valid_in;
   logic [sgu_pkg::OP_W-1:0]              f_op_ff;
   logic signed [sgu_pkg::SAMPLE_W-1:0]   f_sample_ff;
   logic                                  f_fend_ff;
   logic                                  f_bypass_ff;
   logic signed [sgu_pkg::PROD_W-1:0]     f_prod_ff;

   logic                                  accept;
   logic                                  f_adv;
   logic signed [sgu_pkg::PROD_W-1:0]     prod_in;
   logic signed [sgu_pkg::PROD_W-1:0]     biased;
   logic signed [sgu_pkg::PROD_W-1:0]     shifted;
   logic signed [sgu_pkg::SAMPLE_W-1:0]   scaled;

   assign prod_in = sgu_pkg::PROD_W'(req_bus.in_sample)
                  * sgu_pkg::PROD_W'($signed({1'b0, gain_ff}));

   // divide by 1024 rounding toward zero: bias negatives before the shift
   assign biased  = f_prod_ff + (f_prod_ff[sgu_pkg::PROD_W-1]
                    ? sgu_pkg::PROD_W'($signed(1023)) : '0);
   assign shifted = biased >>> sgu_pkg::FRAC_W;

   always_comb begin
      if (f_bypass_ff) begin
         scaled = f_sample_ff;
      end else if (shifted > sgu_pkg::PROD_W'($signed(32767))) begin
         scaled = 16'sh7fff;
      end else if (shifted < -sgu_pkg::PROD_W'($signed(32768))) begin
         scaled = 16'sh8000;
      end else begin
         scaled = shifted[sgu_pkg::SAMPLE_W-1:0];
      end
   end

   // unused op code is dropped here without a queue slot
   assign f_adv      = f_valid_ff && (!q_full || (f_op_ff == sgu_pkg::OP_IGNORE));
   assign push_valid = f_valid_ff && (f_op_ff != sgu_pkg::OP_IGNORE) && !q_full;
   assign req_bus.ready = !f_valid_ff || f_adv;
   assign accept     = req_bus.valid && req_bus.ready;

   assign push_data.op        = f_op_ff;
   assign push_data.sample    = scaled;
   assign push_data.frame_end = f_fend_ff;

   always_comb begin
      f_valid_in = f_valid_ff;
      if (f_adv) begin
         f_valid_in = 1'b0;
      end
      if (accept) begin
         f_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= sgu_pkg::GAIN_RESET;
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_op_ff     <= req_bus.op;
         f_sample_ff <= req_bus.in_sample;
         f_fend_ff   <= req_bus.frame_end;
         f_bypass_ff <= (gain_ff >= sgu_pkg::GAIN_BYPASS);
         f_prod_ff   <= prod_in;
      end
   end

endmodule

// ===== src/sgu_queue.sv =====
// Short command queue between the front end and the ring back end.
module sgu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  sgu_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output sgu_pkg::cmd_type head,
   output logic             empty
);

   sgu_pkg::cmd_type              slot_ff [sgu_pkg::QUEUE_DEPTH];
   logic [sgu_pkg::QPTR_W-1:0]    wr_ff, wr_in;
   logic [sgu_pkg::QPTR_W-1:0]    rd_ff, rd_in;
   logic [sgu_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                          do_push, do_pop;

   assign full    = (cnt_ff == sgu_pkg::QCNT_W'(sgu_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + sgu_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + sgu_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + sgu_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - sgu_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== src/sgu_back.sv =====
// Back end: reference ring memory, pointer bookkeeping, hold-upsampler and output register.
module sgu_back #(
   parameter int REF_DEPTH = 16384,
   parameter int UPSAMPLE  = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  sgu_pkg::cmd_type q_head,
   output logic             q_pop,
   sgu_rsp_if.source        rsp_bus
);

   localparam int PTR_W  = $clog2(REF_DEPTH);
   localparam int FILL_W = $clog2(REF_DEPTH + 1);
   localparam int CNT_W  = $clog2(UPSAMPLE + 1);

   logic [sgu_pkg::SAMPLE_W-1:0]        ring_mem [REF_DEPTH];
   logic [sgu_pkg::SAMPLE_W-1:0]        mem_rd_ff;

   logic [PTR_W-1:0]                    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]                   fill_ff, fill_in;

   logic                                b_busy_ff, b_busy_in;
   logic                                b_kind_ff, b_kind_in;
   logic signed [sgu_pkg::SAMPLE_W-1:0] b_sample_ff, b_sample_in;
   logic                                b_fend_ff, b_fend_in;
   logic                                b_uflow_ff, b_uflow_in;
   logic [CNT_W-1:0]                    b_cnt_ff, b_cnt_in;

   logic                                o_valid_ff, o_valid_in;
   logic                                o_kind_ff;
   logic signed [sgu_pkg::SAMPLE_W-1:0] o_sample_ff, o_sample_in;
   logic                                o_last_ff;
   logic                                o_pend_ff;
   logic                                o_uflow_ff;

   logic emit, last_copy, free;
   logic is_play, is_read, is_clear;
   logic ring_empty, ring_full;
   logic mem_we, mem_re;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(REF_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign emit      = b_busy_ff && (!o_valid_ff || rsp_bus.ready);
   assign last_copy = (b_cnt_ff == CNT_W'(1));
   // the next command may start in the cycle the current one emits its last beat
   assign free      = !b_busy_ff || (emit && last_copy);
   assign q_pop     = free && !q_empty;

   assign is_play  = (q_head.op == sgu_pkg::OP_PLAY);
   assign is_read  = (q_head.op == sgu_pkg::OP_READ);
   assign is_clear = (q_head.op == sgu_pkg::OP_CLEAR);

   assign ring_empty = (fill_ff == '0);
   assign ring_full  = (fill_ff == FILL_W'(REF_DEPTH));
   assign mem_we     = q_pop && is_play;
   assign mem_re     = q_pop && is_read && !ring_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (q_pop) begin
         if (is_play) begin
            wr_ptr_in = ptr_next(wr_ptr_ff);
            if (ring_full) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);   // overwrite drops the oldest
            end else begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end else if (is_read && !ring_empty) begin
            rd_ptr_in = ptr_next(rd_ptr_ff);
            fill_in   = fill_ff - FILL_W'(1);
         end else if (is_clear) begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
            fill_in   = '0;
         end
      end
   end

   always_comb begin
      b_busy_in   = b_busy_ff;
      b_kind_in   = b_kind_ff;
      b_sample_in = b_sample_ff;
      b_fend_in   = b_fend_ff;
      b_uflow_in  = b_uflow_ff;
      b_cnt_in    = b_cnt_ff;
      if (emit) begin
         b_cnt_in = b_cnt_ff - CNT_W'(1);
         if (last_copy) begin
            b_busy_in = 1'b0;
         end
      end
      if (q_pop && (is_play || is_read)) begin
         b_busy_in   = 1'b1;
         b_kind_in   = is_play ? sgu_pkg::KIND_SPEAKER : sgu_pkg::KIND_REF;
         b_sample_in = q_head.sample;
         b_fend_in   = is_play && q_head.frame_end;
         b_uflow_in  = is_read && ring_empty;
         b_cnt_in    = is_play ? CNT_W'(UPSAMPLE) : CNT_W'(1);
      end
   end

   always_comb begin
      if (b_kind_ff == sgu_pkg::KIND_REF) begin
         o_sample_in = b_uflow_ff ? '0 : $signed(mem_rd_ff);
      end else begin
         o_sample_in = b_sample_ff;
      end
      o_valid_in = o_valid_ff;
      if (emit) begin
         o_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         b_busy_ff  <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         fill_ff    <= fill_in;
         b_busy_ff  <= b_busy_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_kind_ff   <= b_kind_in;
      b_sample_ff <= b_sample_in;
      b_fend_ff   <= b_fend_in;
      b_uflow_ff  <= b_uflow_in;
      b_cnt_ff    <= b_cnt_in;
      if (emit) begin
         o_kind_ff   <= b_kind_ff;
         o_sample_ff <= o_sample_in;
         o_last_ff   <= last_copy;
         o_pend_ff   <= last_copy && b_fend_ff;
         o_uflow_ff  <= b_uflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_ptr_ff] <= q_head.sample;
      end
      if (mem_re) begin
         mem_rd_ff <= ring_mem[rd_ptr_ff];
      end
   end

   assign rsp_bus.valid      = o_valid_ff;
   assign rsp_bus.kind       = o_kind_ff;
   assign rsp_bus.sample     = o_sample_ff;
   assign rsp_bus.last       = o_last_ff;
   assign rsp_bus.packet_end = o_pend_ff;
   assign rsp_bus.underflow  = o_uflow_ff;

endmodule
